[src/fvtc_pkg.sv]
// ---------------------------------------------------------------------------
// FIFO victim tile cache package
// Shared widths, operation codes and the result word type.
// ---------------------------------------------------------------------------
package fvtc_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int CAP_W     = 5;
  localparam int TILE_W    = 16;
  localparam int FILL_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic              hit;
    logic              evict_valid;
    logic [TILE_W-1:0] evict_tile;
    logic [FILL_W-1:0] fill_level;
  } fvtc_res_t;

endpackage

[src/fifo_victim_tile_cache_unit.sv]
// ---------------------------------------------------------------------------
// FIFO victim tile cache unit
// An insert writes the tile, first evicting the oldest entry when full; a lookup
// scans entries newest to oldest and, on a hit, moves each younger entry down.
// One word is in work at a time; the single tile memory sets the pace.
// Reset empties the cache and sets the capacity to 16; memory is not cleared.
// ---------------------------------------------------------------------------
module fifo_victim_tile_cache_unit import fvtc_pkg::*; #(
  parameter int CACHE_DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [TILE_W-1:0] in_tile_id,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_hit,
  output logic              out_evict_valid,
  output logic [TILE_W-1:0] out_evict_tile,
  output logic [FILL_W-1:0] out_fill_level,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_cache_capacity
);

  logic [CAP_W-1:0] cap_r;
  logic             out_valid_r;
  fvtc_res_t        out_r;
  logic             core_idle;
  logic             core_res_valid;
  logic             res_take;
  fvtc_res_t        core_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = !core_idle;
  assign res_take  = core_res_valid && (!out_valid_r || !out_stall);

  fvtc_core #(
    .CACHE_DEPTH(CACHE_DEPTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_valid && core_idle),
    .op       (in_op),
    .tile_id  (in_tile_id),
    .cap      (cap_r),
    .idle     (core_idle),
    .res_valid(core_res_valid),
    .res_take (res_take),
    .res      (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_cache_capacity;
      end
      if (res_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= core_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_r.hit;
  assign out_evict_valid = out_r.evict_valid;
  assign out_evict_tile  = out_r.evict_tile;
  assign out_fill_level  = out_r.fill_level;

endmodule

[src/fvtc_core.sv]
// ---------------------------------------------------------------------------
// FIFO victim tile cache engine
// Ring buffer of tiles in one memory, scanned newest to oldest and compacted
// one entry per cycle.
// ---------------------------------------------------------------------------
module fvtc_core import fvtc_pkg::*; #(
  parameter int CACHE_DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              op,
  input  logic [TILE_W-1:0] tile_id,
  input  logic [CAP_W-1:0]  cap,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_take,
  output fvtc_res_t         res
);

  localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CW = $clog2(CACHE_DEPTH + 1);
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LCMP  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_EVICT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [TILE_W-1:0] tile_r, tile_nxt;
  fvtc_res_t         res_r, res_nxt;

  logic [TILE_W-1:0] mem [0:CACHE_DEPTH-1];
  logic [TILE_W-1:0] rd_data_r;
  logic [CW-1:0]     rd_j;
  logic [AW-1:0]     rd_addr;
  logic              we;
  logic [AW-1:0]     wr_addr;
  logic [TILE_W-1:0] wr_data;

  logic [MW-1:0]     cap_eff;
  logic              full;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] j);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(j);
    if (s >= (CW+1)'(CACHE_DEPTH)) begin
      s = s - (CW+1)'(CACHE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    if (MW'(cap) > MW'(CACHE_DEPTH)) begin
      cap_eff = MW'(CACHE_DEPTH);
    end else begin
      cap_eff = MW'(cap);
    end
  end

  assign full      = (MW'(count_r) >= cap_eff);
  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;
  assign rd_addr   = phys(head_r, rd_j);

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    tile_nxt  = tile_r;
    res_nxt   = res_r;
    rd_j      = '0;
    we        = 1'b0;
    wr_addr   = phys(head_r, count_r);
    wr_data   = tile_id;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          tile_nxt            = tile_id;
          res_nxt.hit         = 1'b0;
          res_nxt.evict_valid = 1'b0;
          res_nxt.evict_tile  = '0;
          res_nxt.fill_level  = FILL_W'(count_r);
          if (op == OP_LOOKUP) begin
            if (count_r == '0) begin
              state_nxt = S_DONE;
            end else begin
              rd_j      = count_r - CW'(1);
              idx_nxt   = count_r - CW'(1);
              state_nxt = S_LCMP;
            end
          end else if (cap_eff == '0) begin
            res_nxt.evict_valid = 1'b1;
            res_nxt.evict_tile  = tile_id;
            state_nxt           = S_DONE;
          end else if (full) begin
            state_nxt = S_EVICT;
          end else begin
            we                 = 1'b1;
            count_nxt          = count_r + CW'(1);
            res_nxt.fill_level = FILL_W'(count_r + CW'(1));
            state_nxt          = S_DONE;
          end
        end
      end
      S_LCMP: begin
        if (rd_data_r == tile_r) begin
          if (idx_r + CW'(1) < count_r) begin
            rd_j      = idx_r + CW'(1);
            state_nxt = S_SHIFT;
          end else begin
            count_nxt          = count_r - CW'(1);
            res_nxt.hit        = 1'b1;
            res_nxt.fill_level = FILL_W'(count_r - CW'(1));
            state_nxt          = S_DONE;
          end
        end else if (idx_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          rd_j    = idx_r - CW'(1);
          idx_nxt = idx_r - CW'(1);
        end
      end
      S_SHIFT: begin
        we      = 1'b1;
        wr_addr = phys(head_r, idx_r);
        wr_data = rd_data_r;
        idx_nxt = idx_r + CW'(1);
        if (idx_r + CW'(2) < count_r) begin
          rd_j = idx_r + CW'(2);
        end else begin
          count_nxt          = count_r - CW'(1);
          res_nxt.hit        = 1'b1;
          res_nxt.fill_level = FILL_W'(count_r - CW'(1));
          state_nxt          = S_DONE;
        end
      end
      S_EVICT: begin
        we                  = 1'b1;
        wr_data             = tile_r;
        res_nxt.evict_valid = 1'b1;
        res_nxt.evict_tile  = rd_data_r;
        if (head_r == AW'(CACHE_DEPTH - 1)) begin
          head_nxt = '0;
        end else begin
          head_nxt = head_r + AW'(1);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    tile_r <= tile_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

[tb/fvtc_result_check.sv]
// ---------------------------------------------------------------------------
// FIFO victim tile cache result checker
// Watches the input, result and capacity channels of the cache unit, keeps
// its own copy of the cached tiles, predicts every result word and compares
// it field by field with what the unit returns.
// ---------------------------------------------------------------------------
module fvtc_result_check import fvtc_pkg::*; #(
  parameter int CACHE_DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_op,
  input  logic [TILE_W-1:0] in_tile_id,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_hit,
  input  logic              out_evict_valid,
  input  logic [TILE_W-1:0] out_evict_tile,
  input  logic [FILL_W-1:0] out_fill_level,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_cache_capacity,
  output int                error_count,
  output int                pending_words,
  output int                hit_words,
  output int                evict_words
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [TILE_W-1:0] tile_slots [CACHE_DEPTH];
  int                slot_count;
  logic [CAP_W-1:0]  capacity;
  fvtc_res_t         expected_words [$];

  function automatic fvtc_res_t apply_tile_event(logic op, logic [TILE_W-1:0] tile);
    fvtc_res_t res;
    int        limit;
    int        idx;
    res = '0;
    limit = (capacity > CACHE_DEPTH) ? CACHE_DEPTH : int'(capacity);
    if (op == OP_LOOKUP) begin
      idx = slot_count - 1;
      while (idx >= 0 && tile_slots[idx] != tile) idx--;
      if (idx >= 0) begin
        for (int k = idx; k < slot_count - 1; k++) tile_slots[k] = tile_slots[k + 1];
        slot_count--;
        res.hit = 1'b1;
      end
    end else if (limit == 0) begin
      res.evict_valid = 1'b1;
      res.evict_tile  = tile;
    end else begin
      if (slot_count >= limit) begin
        res.evict_valid = 1'b1;
        res.evict_tile  = tile_slots[0];
        for (int k = 0; k < slot_count - 1; k++) tile_slots[k] = tile_slots[k + 1];
        slot_count--;
      end
      if (slot_count < CACHE_DEPTH) begin
        tile_slots[slot_count] = tile;
        slot_count++;
      end
    end
    res.fill_level = FILL_W'(slot_count);
    return res;
  endfunction

  function automatic void compare_field(string field, logic [TILE_W-1:0] want,
                                        logic [TILE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    fvtc_res_t want;
    if (!rst_n) begin
      expected_words.delete();
      slot_count = 0;
      capacity   = CAP_RESET;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word with no expectation waiting");
          error_count++;
        end else begin
          want = expected_words.pop_front();
          compare_field("hit", TILE_W'(want.hit), TILE_W'(out_hit));
          compare_field("evict_valid", TILE_W'(want.evict_valid), TILE_W'(out_evict_valid));
          compare_field("evict_tile", want.evict_tile, out_evict_tile);
          compare_field("fill_level", TILE_W'(want.fill_level), TILE_W'(out_fill_level));
          if (want.hit) hit_words++;
          if (want.evict_valid) evict_words++;
        end
      end
      if (in_valid && !in_stall)
        expected_words.insert(expected_words.size(), apply_tile_event(in_op, in_tile_id));
      if (cfg_valid && cfg_ready) capacity = cfg_cache_capacity;
    end
    pending_words = expected_words.size();
  end

endmodule

[tb/fifo_victim_tile_cache_unit_test.sv]
// ---------------------------------------------------------------------------
// FIFO victim tile cache unit testbench
// Drives directed and random hide and show events through the cache unit
// under several capacity settings, with random idling on both channels, and
// takes the verdict from the result checker.
// ---------------------------------------------------------------------------
module fifo_victim_tile_cache_unit_test import fvtc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES    = 2 * DEPTH_DEF + 4;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 115;

  logic              clk                = 1'b0;
  logic              rst_n              = 1'b0;
  logic              in_valid           = 1'b0;
  logic              in_stall;
  logic              in_op              = OP_LOOKUP;
  logic [TILE_W-1:0] in_tile_id         = '0;
  logic              out_valid;
  logic              out_stall          = 1'b1;
  logic              out_hit;
  logic              out_evict_valid;
  logic [TILE_W-1:0] out_evict_tile;
  logic [FILL_W-1:0] out_fill_level;
  logic              cfg_valid          = 1'b0;
  logic              cfg_ready;
  logic [CAP_W-1:0]  cfg_cache_capacity = CAP_RESET;

  int error_count;
  int pending_words;
  int hit_words;
  int evict_words;
  int cycle_count    = 0;
  int capacity_writes = 0;
  bit steady_flow    = 1'b0;

  logic [TILE_W-1:0] hidden_ids [$];
  logic [CAP_W-1:0]  phase_caps [8] = '{5'd31, 5'd3, 5'd16, 5'd0, 5'd1, 5'd8, 5'd17, 5'd5};

  fifo_victim_tile_cache_unit #(.CACHE_DEPTH(DEPTH_DEF)) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_tile_id         (in_tile_id),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_hit            (out_hit),
    .out_evict_valid    (out_evict_valid),
    .out_evict_tile     (out_evict_tile),
    .out_fill_level     (out_fill_level),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_cache_capacity (cfg_cache_capacity)
  );

  fvtc_result_check #(.CACHE_DEPTH(DEPTH_DEF)) result_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_tile_id         (in_tile_id),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_hit            (out_hit),
    .out_evict_valid    (out_evict_valid),
    .out_evict_tile     (out_evict_tile),
    .out_fill_level     (out_fill_level),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_cache_capacity (cfg_cache_capacity),
    .error_count        (error_count),
    .pending_words      (pending_words),
    .hit_words          (hit_words),
    .evict_words        (evict_words)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("fifo_victim_tile_cache_unit_test: done, errors");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (steady_flow) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
  endfunction

  task automatic send_word(logic op, logic [TILE_W-1:0] tile);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_tile_id <= tile;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_words != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    wait_drained();
    cfg_valid          <= 1'b1;
    cfg_cache_capacity <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    capacity_writes++;
  endtask

  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  initial begin
    logic [TILE_W-1:0] tile;
    int                pick;
    phase_caps[7] = CAP_W'($urandom_range(0, 31));
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_word(OP_LOOKUP, 16'h0000);
    send_word(OP_INSERT, 16'h0000);
    send_word(OP_INSERT, 16'hFFFF);
    send_word(OP_INSERT, 16'h5A5A);
    send_word(OP_INSERT, 16'h5A5A);
    send_word(OP_INSERT, 16'hA5A5);
    send_word(OP_LOOKUP, 16'h5A5A);
    send_word(OP_LOOKUP, 16'hFFFF);
    send_word(OP_LOOKUP, 16'h1357);
    write_capacity(5'd1);
    send_word(OP_INSERT, 16'h0F0F);
    send_word(OP_INSERT, 16'hF0F0);
    write_capacity(5'd0);
    send_word(OP_INSERT, 16'h2468);
    send_word(OP_LOOKUP, 16'hA5A5);
    write_capacity(5'd31);
    for (int i = 0; i < 15; i++) send_word(OP_INSERT, TILE_W'(1) << i);

    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      steady_flow = (p % 3 == 2);
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 55) begin
          if (hidden_ids.size() > 0 && $urandom_range(0, 19) == 0)
            tile = hidden_ids[$urandom_range(0, hidden_ids.size() - 1)];
          else if ($urandom_range(0, 1) == 1)
            tile = TILE_W'($urandom_range(0, 65535));
          else
            tile = TILE_W'($urandom_range(0, 63));
          hidden_ids.insert(hidden_ids.size(), tile);
          if (hidden_ids.size() > 48) void'(hidden_ids.pop_front());
          send_word(OP_INSERT, tile);
        end else begin
          if (hidden_ids.size() > 0 && $urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, hidden_ids.size() - 1);
            tile = hidden_ids[pick];
            hidden_ids.delete(pick);
          end else begin
            tile = TILE_W'($urandom_range(0, 65535));
          end
          send_word(OP_LOOKUP, tile);
        end
      end
    end
    steady_flow = 1'b0;

    wait_drained();
    $display("Exercised %0d cache hits and %0d expired tiles across %0d capacity writes,",
             hit_words, evict_words, capacity_writes);
    $display("including zero capacity, capacity above depth and shrinking below fill.");
    if (error_count == 0 && pending_words == 0)
      $display("fifo_victim_tile_cache_unit_test: done, clean");
    else
      $display("fifo_victim_tile_cache_unit_test: done, errors");
    $finish;
  end

endmodule

[fifo_victim_tile_cache_unit.f]
src/fvtc_pkg.sv
src/fvtc_core.sv
src/fifo_victim_tile_cache_unit.sv
tb/fvtc_result_check.sv
tb/fifo_victim_tile_cache_unit_test.sv
